### hw/rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned CpW = 21;

  // continuation bytes still expected, also used for the sequence length
  localparam logic [1:0] SEQ_IDLE  = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  localparam logic [CpW-1:0] MIN_TWO   = 21'h00080;
  localparam logic [CpW-1:0] MIN_THREE = 21'h00800;
  localparam logic [CpW-1:0] MIN_FOUR  = 21'h10000;
  localparam logic [CpW-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO   = 21'h0D800;
  localparam logic [CpW-1:0] SURR_HI   = 21'h0DFFF;

  typedef struct packed {
    logic [CpW-1:0] partial_value;
    logic [1:0]     bytes_left;
    logic [1:0]     sequence_length;
  } u8d_state_t;

  typedef struct packed {
    u8d_state_t     nxt;
    logic           emit;
    logic [CpW-1:0] codepoint;
  } u8d_step_t;

endpackage

### hw/rtl/u8d_step.sv
module u8d_step (
  input  u8d_pkg::u8d_state_t st,
  input  logic [7:0]          data_byte,
  input  logic                end_of_text,
  output u8d_pkg::u8d_step_t  res
);
  import u8d_pkg::*;

  logic           is_cont;
  logic [CpW-1:0] acc;
  logic [1:0]     left_dec;
  logic [CpW-1:0] min_val;
  logic           acc_ok;

  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign acc      = {st.partial_value[CpW-7:0], data_byte[5:0]};
  assign left_dec = st.bytes_left - 2'd1;

  always_comb begin
    unique case (st.sequence_length)
      SEQ_TWO:   min_val = MIN_TWO;
      SEQ_THREE: min_val = MIN_THREE;
      default:   min_val = MIN_FOUR;
    endcase
  end

  assign acc_ok = (acc >= min_val) && (acc <= CP_MAX) &&
                  !((acc >= SURR_LO) && (acc <= SURR_HI));

  always_comb begin
    res           = '0;
    res.codepoint = acc;
    if ((st.bytes_left != SEQ_IDLE) && is_cont) begin
      if (left_dec == SEQ_IDLE) begin
        // last continuation: emit only a valid scalar, then go idle
        res.emit = acc_ok;
      end else begin
        res.nxt.partial_value   = acc;
        res.nxt.bytes_left      = left_dec;
        res.nxt.sequence_length = st.sequence_length;
      end
    end else begin
      // idle, or a broken sequence restarting on this byte
      priority if (data_byte[7] == 1'b0) begin
        res.emit      = 1'b1;
        res.codepoint = {14'd0, data_byte[6:0]};
      end else if (data_byte[7:5] == 3'b110) begin
        res.nxt.partial_value   = {16'd0, data_byte[4:0]};
        res.nxt.bytes_left      = SEQ_TWO;
        res.nxt.sequence_length = SEQ_TWO;
      end else if (data_byte[7:4] == 4'b1110) begin
        res.nxt.partial_value   = {17'd0, data_byte[3:0]};
        res.nxt.bytes_left      = SEQ_THREE;
        res.nxt.sequence_length = SEQ_THREE;
      end else if (data_byte[7:3] == 5'b11110) begin
        res.nxt.partial_value   = {18'd0, data_byte[2:0]};
        res.nxt.bytes_left      = SEQ_FOUR;
        res.nxt.sequence_length = SEQ_FOUR;
      end else begin
        // stray continuation or invalid lead
        res.nxt = '0;
      end
    end
    if (end_of_text && (res.nxt.bytes_left != SEQ_IDLE)) begin
      res.nxt = '0;
    end
  end

endmodule

### hw/rtl/u8d_out_reg.sv
module u8d_out_reg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic                     emit,
  input  logic [u8d_pkg::CpW-1:0]  codepoint,
  output logic                     free,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [u8d_pkg::CpW-1:0]  out_codepoint
);
  import u8d_pkg::*;

  logic           valid_r;
  logic           valid_nxt;
  logic [CpW-1:0] cp_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && emit) begin
      cp_r <= codepoint;
    end
  end

  assign out_valid     = valid_r;
  assign out_codepoint = cp_r;

endmodule

### hw/rtl/utf8_stream_decoder.sv
// utf8_stream_decoder: validating utf-8 decoder, one byte per word in,
// one unicode scalar value per word out
// input channel: in_valid / in_stall with in_data_byte and in_end_of_text;
//   set in_end_of_text on the last byte of a text so a truncated sequence
//   is dropped and the next byte starts clean
// output channel: out_valid / out_stall with out_codepoint (21 bits)
// malformed input (stray continuations, bad leads, overlong forms,
//   surrogates, values above 0x10ffff) produces no output word
// path: a byte taken into the input register is decoded from there into the
//   output register, which drives out_codepoint (two registers deep)
// throughput: one byte per clock while out_stall does not block the output;
//   the decode between the input and output registers is combinational
// stall: while out_stall holds a pending word, the byte in the input
//   register waits and in_stall goes high in the same cycle
// reset (rst_n low, synchronous): both registers empty, decoder idle
module utf8_stream_decoder (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_end_of_text,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [u8d_pkg::CpW-1:0] out_codepoint
);
  import u8d_pkg::*;

  // input register
  logic       in_vld_r;
  logic       in_vld_nxt;
  logic [7:0] byte_r;
  logic       eot_r;

  // decoder state
  u8d_state_t st_r;
  u8d_state_t st_nxt;
  u8d_step_t  step;

  logic out_free;
  logic advance;
  logic in_load;

  // the byte in the input register moves on when the output side can take
  // whatever it produces
  assign advance  = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_load  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (advance) begin
      in_vld_nxt = 1'b0;
    end
    if (in_load) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      byte_r <= in_data_byte;
      eot_r  <= in_end_of_text;
    end
  end

  // combinational decode of one byte against the pending sequence
  u8d_step u_step (
    .st          (st_r),
    .data_byte   (byte_r),
    .end_of_text (eot_r),
    .res         (step)
  );

  assign st_nxt = advance ? step.nxt : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // result register
  u8d_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (advance),
    .emit          (step.emit),
    .codepoint     (step.codepoint),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_codepoint (out_codepoint)
  );

`ifndef SYNTH
  a_left_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bytes_left <= st_r.sequence_length)
    else $error("pending count exceeds sequence length");

  a_len_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.bytes_left != SEQ_IDLE) |-> (st_r.sequence_length != SEQ_IDLE))
    else $error("sequence pending without a length");

  a_scalar_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_codepoint <= CP_MAX) &&
                   !((out_codepoint >= SURR_LO) && (out_codepoint <= SURR_HI))))
    else $error("output word is not a unicode scalar value");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && in_vld_r))
    else $error("input stalled without a blocked output");

  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && eot_r) |=> (st_r.bytes_left == SEQ_IDLE))
    else $error("sequence still pending after end of text");
`endif

endmodule
